### rtl/wulb_pkg.sv
// Shared types and constants of the weighted unit load balancer.
package wulb_pkg;

  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_SETLOAD = 3'd1;
  localparam logic [2:0] CMD_ALLOC   = 3'd2;
  localparam logic [2:0] CMD_FREE    = 3'd3;
  localparam logic [2:0] CMD_BEST    = 3'd4;
  localparam logic [2:0] CMD_SPLIT   = 3'd5;

  localparam logic [17:0] Q_ONE       = 18'd65536;
  localparam logic [16:0] Q_LOAD_CAP  = 17'd58982;
  localparam logic [16:0] Q_MEM_FLOOR = 17'd6554;
  localparam logic [16:0] Q_HALF      = 17'd32768;
  localparam logic [47:0] MASK48      = 48'hFFFF_FFFF_FFFF;

  typedef enum logic {AOP_MUL, AOP_DIV} aop_t;

  typedef struct packed {
    logic        start;
    aop_t        op;
    logic [65:0] a;
    logic [47:0] b;
    logic [6:0]  steps;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [65:0] res;
  } arith_rsp_t;

  typedef struct packed {
    logic [7:0]  ident;
    logic [47:0] cap;
    logic [47:0] used;
    logic [16:0] load;
  } entry_t;

  typedef struct packed {
    logic        load_en;
    logic        load_q_en;
    logic        used_en;
    logic [7:0]  ident;
    logic [47:0] cap;
    logic [47:0] used;
    logic [16:0] load;
  } tbl_wr_t;

endpackage

### rtl/wulb_arith.sv
// Shared iterative unit: one-bit-per-cycle shift-add multiply and restoring divide.
module wulb_arith import wulb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  aop_t        op_r;
  logic [65:0] x_r;
  logic [65:0] y_r;
  logic [47:0] b_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [48:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh = {y_r[47:0], x_r[65]};
    fits   = rem_sh >= {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r   <= req.op;
        x_r    <= req.a;
        y_r    <= '0;
        b_r    <= req.b;
        cnt_r  <= req.steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (op_r == AOP_DIV) begin
          x_r <= {x_r[64:0], fits};
          y_r <= {17'd0, fits ? (rem_sh - {1'b0, b_r}) : rem_sh};
        end else begin
          if (b_r[0]) begin
            y_r <= y_r + x_r;
          end
          x_r <= {x_r[64:0], 1'b0};
          b_r <= {1'b0, b_r[47:1]};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = (op_r == AOP_DIV) ? x_r : y_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("unit not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == 7'd1) |=> done_r) else $error("missing done");

endmodule

### rtl/wulb_table.sv
// Table of compute-unit descriptors with one write port and one read port.
module wulb_table import wulb_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int IW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] wr_addr,
  input  tbl_wr_t       wr,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd
);

  entry_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        mem_r[i] <= '0;
      end
    end else begin
      if (wr.load_en) begin
        mem_r[wr_addr] <= '{ident: wr.ident, cap: wr.cap, used: 48'd0, load: 17'd0};
      end
      if (wr.load_q_en) begin
        mem_r[wr_addr].load <= wr.load;
      end
      if (wr.used_en) begin
        mem_r[wr_addr].used <= wr.used;
      end
    end
  end

  assign rd = mem_r[rd_addr];

endmodule

### rtl/weighted_unit_load_balancer.sv
// Top level: command sequencer of the weighted unit load balancer.
// Load-unit and set-load requests complete at acceptance; allocate and free scan the slots until the unit is found.
// One request at a time; a result waits in the output register while the next request is taken.
// Synchronous reset clears the table, the unit count, the sequencer state and the output valid flag.
module weighted_unit_load_balancer import wulb_pkg::*; #(
  parameter int MAX_UNITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_unit_id,
  input  logic [47:0] in_amount,
  input  logic [16:0] in_load_level,
  input  logic [31:0] in_total_work,
  input  logic [15:0] in_group_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_best_found,
  output logic [2:0]  out_best_slot,
  output logic [7:0]  out_range_unit_id,
  output logic [32:0] out_range_offset,
  output logic [32:0] out_range_count,
  output logic        out_last
);

  localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CW = $clog2(MAX_UNITS + 1);
  localparam int SW = 18 + IW;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIND, ST_BEST_CHK, ST_BEST_M2, ST_BEST_CMP, ST_SP_ONE,
    ST_SP_ALDIV, ST_SP_ALMUL, ST_SP_ALSET, ST_W_CHK, ST_W_MEM, ST_W_MUL, ST_W_ACC,
    ST_C_CHK, ST_C_DIV, ST_C_RDIV, ST_C_RMUL, ST_C_MIN, ST_C_OUT, ST_WAIT
  } state_t;

  state_t      state_r;
  state_t      ret_r;
  arith_req_t  arq_r;
  arith_rsp_t  rsp;
  logic [3:0]  unit_count_r;
  logic [CW-1:0] idx_r;
  logic [2:0]  cmd_r;
  logic [7:0]  id_r;
  logic [47:0] amt_r;
  logic [31:0] tot_r;
  logic [15:0] g_r;
  logic        found_r;
  logic [IW-1:0] best_r;
  logic [47:0] bf_r;
  logic [17:0] bm_r;
  logic [65:0] p_r;
  logic [16:0] mem_r;
  logic [17:0] w_r [MAX_UNITS];
  logic [SW-1:0] sum_r;
  logic [32:0] aligned_r;
  logic [32:0] assigned_r;
  logic [32:0] chunk_r;
  logic        out_valid_r;
  logic        best_found_r;
  logic [2:0]  best_slot_r;
  logic [7:0]  range_id_r;
  logic [32:0] range_off_r;
  logic [32:0] range_cnt_r;
  logic        last_r;

  logic [CW-1:0] n_act;
  logic          accept;
  logic          out_free;
  logic          out_push;
  logic [IW+2:0] slot_x;
  logic [IW+2:0] best_x;
  logic [IW-1:0] tw_addr;
  tbl_wr_t       tw;
  entry_t        rd;
  logic [47:0]   free_cur;
  logic          elig;
  logic [17:0]   m_cur;
  logic [16:0]   ld_cl;
  logic [17:0]   a_w;
  logic [48:0]   used_sum;
  logic [32:0]   remain;
  logic [33:0]   c_up;
  logic          idx_last;

  assign n_act    = (unit_count_r < MAX_UNITS) ? CW'(unit_count_r) : CW'(MAX_UNITS);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_push = out_free && ((state_r == ST_BEST_CHK && idx_r == n_act) ||
                                 state_r == ST_SP_ONE || state_r == ST_C_OUT);
  assign slot_x   = {{IW{1'b0}}, in_slot};
  assign best_x   = {3'b000, best_r};
  assign idx_last = (idx_r == n_act - CW'(1));

  always_comb begin
    free_cur = rd.cap - rd.used;
    elig     = (rd.used <= rd.cap) && (free_cur >= amt_r);
    m_cur    = Q_ONE + {1'b0, rd.load};
    ld_cl    = (rd.load < Q_LOAD_CAP) ? rd.load : Q_LOAD_CAP;
    a_w      = Q_ONE + (Q_ONE - {1'b0, ld_cl});
    used_sum = {1'b0, rd.used} + {1'b0, amt_r};
    remain   = aligned_r - assigned_r;
    c_up     = {1'b0, rsp.res[32:0]} + {18'd0, g_r} - 34'd1;
  end

  always_comb begin
    tw      = '0;
    tw_addr = slot_x[IW-1:0];
    tw.ident = in_unit_id;
    tw.cap   = in_amount;
    tw.load  = in_load_level;
    if (accept && in_cmd == CMD_LOAD && slot_x < MAX_UNITS) begin
      tw.load_en = 1'b1;
    end
    if (accept && in_cmd == CMD_SETLOAD && slot_x < n_act) begin
      tw.load_q_en = 1'b1;
    end
    if (state_r == ST_FIND && idx_r != n_act && rd.ident == id_r) begin
      tw_addr    = idx_r[IW-1:0];
      tw.used_en = 1'b1;
      if (cmd_r == CMD_ALLOC) begin
        tw.used = used_sum[48] ? MASK48 : used_sum[47:0];
      end else begin
        tw.used = (rd.used >= amt_r) ? (rd.used - amt_r) : 48'd0;
      end
    end
  end

  wulb_table #(.DEPTH(MAX_UNITS), .IW(IW)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_addr (tw_addr),
    .wr      (tw),
    .rd_addr (idx_r[IW-1:0]),
    .rd      (rd)
  );

  wulb_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arq_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      arq_r        <= '0;
      unit_count_r <= 4'd0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unit_count_r <= cfg_wr_data;
      end
      if (out_push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= in_cmd;
            id_r    <= in_unit_id;
            amt_r   <= in_amount;
            tot_r   <= in_total_work;
            g_r     <= (in_group_size == 16'd0) ? 16'd1 : in_group_size;
            idx_r   <= '0;
            found_r <= 1'b0;
            best_r  <= '0;
            case (in_cmd)
              CMD_ALLOC, CMD_FREE: state_r <= ST_FIND;
              CMD_BEST:            state_r <= ST_BEST_CHK;
              CMD_SPLIT: begin
                if (n_act == CW'(1)) begin
                  state_r <= ST_SP_ONE;
                end else if (n_act != CW'(0)) begin
                  state_r <= ST_SP_ALDIV;
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_FIND: begin
          if (idx_r == n_act || rd.ident == id_r) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        ST_BEST_CHK: begin
          if (idx_r == n_act) begin
            if (out_free) begin
              best_found_r <= found_r;
              best_slot_r  <= found_r ? best_x[2:0] : 3'd0;
              range_id_r   <= 8'd0;
              range_off_r  <= 33'd0;
              range_cnt_r  <= 33'd0;
              last_r       <= 1'b1;
              state_r      <= ST_IDLE;
            end
          end else if (!elig) begin
            idx_r <= idx_r + CW'(1);
          end else if (!found_r) begin
            found_r <= 1'b1;
            best_r  <= idx_r[IW-1:0];
            bf_r    <= free_cur;
            bm_r    <= m_cur;
            idx_r   <= idx_r + CW'(1);
          end else begin
            arq_r   <= '{start: 1'b1, op: AOP_MUL, a: {18'd0, free_cur},
                         b: {30'd0, bm_r}, steps: 7'd18};
            ret_r   <= ST_BEST_M2;
            state_r <= ST_WAIT;
          end
        end
        ST_BEST_M2: begin
          p_r     <= rsp.res;
          arq_r   <= '{start: 1'b1, op: AOP_MUL, a: {18'd0, bf_r},
                       b: {30'd0, m_cur}, steps: 7'd18};
          ret_r   <= ST_BEST_CMP;
          state_r <= ST_WAIT;
        end
        ST_BEST_CMP: begin
          if (p_r > rsp.res) begin
            best_r <= idx_r[IW-1:0];
            bf_r   <= free_cur;
            bm_r   <= m_cur;
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= ST_BEST_CHK;
        end
        ST_SP_ONE: begin
          if (out_free) begin
            best_found_r <= 1'b0;
            best_slot_r  <= 3'd0;
            range_id_r   <= rd.ident;
            range_off_r  <= 33'd0;
            range_cnt_r  <= {1'b0, tot_r};
            last_r       <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        ST_SP_ALDIV: begin
          arq_r   <= '{start: 1'b1, op: AOP_DIV,
                       a: {{2'b00, tot_r} + {18'd0, g_r} - 34'd1, 32'd0},
                       b: {32'd0, g_r}, steps: 7'd34};
          ret_r   <= ST_SP_ALMUL;
          state_r <= ST_WAIT;
        end
        ST_SP_ALMUL: begin
          arq_r   <= '{start: 1'b1, op: AOP_MUL, a: rsp.res, b: {32'd0, g_r}, steps: 7'd16};
          ret_r   <= ST_SP_ALSET;
          state_r <= ST_WAIT;
        end
        ST_SP_ALSET: begin
          aligned_r <= rsp.res[32:0];
          sum_r     <= '0;
          idx_r     <= '0;
          state_r   <= ST_W_CHK;
        end
        ST_W_CHK: begin
          if (idx_r == n_act) begin
            idx_r      <= '0;
            assigned_r <= 33'd0;
            state_r    <= ST_C_CHK;
          end else if (rd.cap == 48'd0) begin
            mem_r   <= Q_ONE[16:0] | 17'h10000;
            state_r <= ST_W_MUL;
          end else if (rd.used > rd.cap) begin
            mem_r   <= Q_MEM_FLOOR;
            state_r <= ST_W_MUL;
          end else begin
            arq_r   <= '{start: 1'b1, op: AOP_DIV, a: {free_cur, 18'd0},
                         b: rd.cap, steps: 7'd64};
            ret_r   <= ST_W_MEM;
            state_r <= ST_WAIT;
          end
        end
        ST_W_MEM: begin
          mem_r   <= (rsp.res[16:0] < Q_MEM_FLOOR) ? Q_MEM_FLOOR : rsp.res[16:0];
          state_r <= ST_W_MUL;
        end
        ST_W_MUL: begin
          arq_r   <= '{start: 1'b1, op: AOP_MUL, a: {48'd0, a_w},
                       b: {31'd0, Q_HALF + {1'b0, mem_r[16:1]}}, steps: 7'd18};
          ret_r   <= ST_W_ACC;
          state_r <= ST_WAIT;
        end
        ST_W_ACC: begin
          w_r[idx_r[IW-1:0]] <= rsp.res[33:16];
          sum_r   <= sum_r + {{(SW-18){1'b0}}, rsp.res[33:16]};
          idx_r   <= idx_r + CW'(1);
          state_r <= ST_W_CHK;
        end
        ST_C_CHK: begin
          if (idx_last) begin
            chunk_r <= remain;
            state_r <= ST_C_OUT;
          end else begin
            arq_r   <= '{start: 1'b1, op: AOP_MUL, a: {33'd0, aligned_r},
                         b: {30'd0, w_r[idx_r[IW-1:0]]}, steps: 7'd18};
            ret_r   <= ST_C_DIV;
            state_r <= ST_WAIT;
          end
        end
        ST_C_DIV: begin
          arq_r   <= '{start: 1'b1, op: AOP_DIV, a: {rsp.res[50:0], 15'd0},
                       b: {{(48-SW){1'b0}}, sum_r}, steps: 7'd51};
          ret_r   <= ST_C_RDIV;
          state_r <= ST_WAIT;
        end
        ST_C_RDIV: begin
          arq_r   <= '{start: 1'b1, op: AOP_DIV, a: {c_up, 32'd0},
                       b: {32'd0, g_r}, steps: 7'd34};
          ret_r   <= ST_C_RMUL;
          state_r <= ST_WAIT;
        end
        ST_C_RMUL: begin
          arq_r   <= '{start: 1'b1, op: AOP_MUL, a: rsp.res, b: {32'd0, g_r}, steps: 7'd16};
          ret_r   <= ST_C_MIN;
          state_r <= ST_WAIT;
        end
        ST_C_MIN: begin
          chunk_r <= (rsp.res[33:0] > {1'b0, remain}) ? remain : rsp.res[32:0];
          state_r <= ST_C_OUT;
        end
        ST_C_OUT: begin
          if (out_free) begin
            best_found_r <= 1'b0;
            best_slot_r  <= 3'd0;
            range_id_r   <= rd.ident;
            range_off_r  <= assigned_r;
            range_cnt_r  <= chunk_r;
            last_r       <= idx_last;
            assigned_r   <= assigned_r + chunk_r;
            idx_r        <= idx_r + CW'(1);
            state_r      <= idx_last ? ST_IDLE : ST_C_CHK;
          end
        end
        ST_WAIT: begin
          arq_r.start <= 1'b0;
          if (rsp.done) begin
            state_r <= ret_r;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_best_found    = best_found_r;
  assign out_best_slot     = best_slot_r;
  assign out_range_unit_id = range_id_r;
  assign out_range_offset  = range_off_r;
  assign out_range_count   = range_cnt_r;
  assign out_last          = last_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == ST_WAIT) else $error("arithmetic result outside wait");
  a_start_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    arq_r.start |-> state_r == ST_WAIT) else $error("start issued outside wait");
  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_C_OUT |-> ({1'b0, assigned_r} + {1'b0, chunk_r}) <= {1'b0, aligned_r})
    else $error("split range beyond aligned total");

endmodule

### test/tb_top.sv
// Self-checking testbench of the weighted unit load balancer, with its own table predictor.
module tb_top;
  import wulb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [7:0]  unit_id;
    logic [47:0] amount;
    logic [16:0] load_level;
    logic [31:0] total_work;
    logic [15:0] group_size;
  } request_t;

  typedef struct {
    logic        found;
    logic [2:0]  bslot;
    logic [7:0]  rid;
    logic [32:0] roff;
    logic [32:0] rcnt;
    logic        last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  logic [2:0] in_slot = '0;
  logic [7:0] in_unit_id = '0;
  logic [47:0] in_amount = '0;
  logic [16:0] in_load_level = '0;
  logic [31:0] in_total_work = '0;
  logic [15:0] in_group_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_best_found;
  logic [2:0] out_best_slot;
  logic [7:0] out_range_unit_id;
  logic [32:0] out_range_offset;
  logic [32:0] out_range_count;
  logic out_last;

  weighted_unit_load_balancer uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_t pending[$];
  answer_t  awaited[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  bit hold_req = 0;

  // Predictor copy of the unit table.
  logic [7:0]  p_ident[8];
  logic [47:0] p_cap[8];
  logic [47:0] p_used[8];
  logic [16:0] p_load[8];
  logic [3:0]  p_count;

  function automatic int active_slots();
    return (p_count < 8) ? int'(p_count) : 8;
  endfunction

  function automatic int lookup_slot(logic [7:0] id);
    for (int i = 0; i < active_slots(); i++)
      if (p_ident[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [63:0] split_weight(int i);
    logic [63:0] inv, mem;
    inv = 65536 - ((p_load[i] < 58982) ? p_load[i] : 58982);
    mem = 65536;
    if (p_cap[i] != 0) begin
      if (p_used[i] > p_cap[i]) mem = 6554;
      else begin
        mem = ({64'd0, p_cap[i] - p_used[i]} << 16) / p_cap[i];
        if (mem < 6554) mem = 6554;
      end
    end
    return ((65536 + inv) * (32768 + (mem >> 1))) >> 16;
  endfunction

  task automatic predict_request(request_t r);
    int n, s, best;
    logic [127:0] bf, bm, f, m, sum, aligned, assigned, chunk, g;
    logic [127:0] w[8];
    logic [48:0] u;
    answer_t a;
    n = active_slots();
    a = '{default: '0};
    case (r.cmd)
      CMD_LOAD: begin
        p_ident[r.slot] = r.unit_id;
        p_cap[r.slot] = r.amount;
        p_used[r.slot] = '0;
        p_load[r.slot] = '0;
      end
      CMD_SETLOAD: if (r.slot < n) p_load[r.slot] = r.load_level;
      CMD_ALLOC: begin
        s = lookup_slot(r.unit_id);
        if (s >= 0) begin
          u = {1'b0, p_used[s]} + {1'b0, r.amount};
          p_used[s] = u[48] ? MASK48 : u[47:0];
        end
      end
      CMD_FREE: begin
        s = lookup_slot(r.unit_id);
        if (s >= 0) p_used[s] = (p_used[s] >= r.amount) ? p_used[s] - r.amount : '0;
      end
      CMD_BEST: begin
        best = -1;
        bf = 0;
        bm = 1;
        for (int i = 0; i < n; i++) begin
          if (p_used[i] > p_cap[i]) continue;
          f = p_cap[i] - p_used[i];
          if (f < r.amount) continue;
          m = 65536 + p_load[i];
          if (best < 0 || f * bm > bf * m) begin
            best = i;
            bf = f;
            bm = m;
          end
        end
        a.found = (best >= 0);
        a.bslot = (best >= 0) ? best[2:0] : 3'd0;
        a.last = 1'b1;
        awaited.insert(awaited.size(), a);
      end
      CMD_SPLIT: begin
        if (n == 1) begin
          a.rid = p_ident[0];
          a.rcnt = {1'b0, r.total_work};
          a.last = 1'b1;
          awaited.insert(awaited.size(), a);
        end else if (n > 1) begin
          g = (r.group_size == 0) ? 1 : r.group_size;
          aligned = (r.total_work + g - 1) / g * g;
          sum = 0;
          assigned = 0;
          for (int i = 0; i < n; i++) begin
            w[i] = split_weight(i);
            sum += w[i];
          end
          for (int i = 0; i < n; i++) begin
            chunk = w[i] * aligned / sum;
            chunk = (chunk + g - 1) / g * g;
            if (chunk > aligned - assigned) chunk = aligned - assigned;
            if (i == n - 1) chunk = aligned - assigned;
            a = '{default: '0};
            a.rid = p_ident[i];
            a.roff = assigned[32:0];
            a.rcnt = chunk[32:0];
            a.last = (i == n - 1);
            awaited.insert(awaited.size(), a);
            assigned += chunk;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Driver: offers queued requests, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_request(pending.pop_front());
      if ((!in_valid || !in_stall)) begin
        if (pending.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
          in_valid <= 1'b1;
          in_cmd <= pending[0].cmd;
          in_slot <= pending[0].slot;
          in_unit_id <= pending[0].unit_id;
          in_amount <= pending[0].amount;
          in_load_level <= pending[0].load_level;
          in_total_work <= pending[0].total_work;
          in_group_size <= pending[0].group_size;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the result stall.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          e = awaited.pop_front();
          if (out_best_found !== e.found) report_mismatch("best_found", out_best_found, e.found);
          if (out_best_slot !== e.bslot) report_mismatch("best_slot", out_best_slot, e.bslot);
          if (out_range_unit_id !== e.rid) report_mismatch("unit_id", out_range_unit_id, e.rid);
          if (out_range_offset !== e.roff) report_mismatch("offset", out_range_offset, e.roff);
          if (out_range_count !== e.rcnt) report_mismatch("count", out_range_count, e.rcnt);
          if (out_last !== e.last) report_mismatch("last", out_last, e.last);
        end
      end
      if (hold_req) begin
        hold_cycles <= 600;
        out_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic request_t random_request(bit well_formed);
    request_t r;
    int pick;
    r.cmd = 3'($urandom_range(7));
    r.slot = 3'($urandom_range(7));
    r.unit_id = well_formed ? 8'($urandom_range(10)) : 8'($urandom);
    pick = $urandom_range(3);
    r.amount = (pick == 0) ? 48'({$urandom, $urandom}) : (pick == 1) ? 48'($urandom_range(5000))
             : (pick == 2) ? MASK48 - 48'($urandom_range(3)) : {16'd0, $urandom};
    r.load_level = (pick == 3) ? 17'($urandom) : 17'($urandom_range(65536));
    r.total_work = (pick == 2) ? 32'hFFFF_FFFF - 32'($urandom_range(5)) : $urandom;
    r.group_size = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64));
    if (well_formed && r.cmd > CMD_SPLIT) r.cmd = CMD_SPLIT;
    return r;
  endfunction

  task automatic queue_request(logic [2:0] c, logic [2:0] s, logic [7:0] id, logic [47:0] amt,
                               logic [16:0] ld, logic [31:0] tw, logic [15:0] gs);
    request_t r;
    r = '{cmd: c, slot: s, unit_id: id, amount: amt, load_level: ld,
          total_work: tw, group_size: gs};
    pending.insert(pending.size(), r);
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || in_valid || awaited.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_count(logic [3:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_count = v;
  endtask

  initial begin
    logic [3:0] counts[5];
    counts = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd5};
    foreach (p_ident[i]) begin
      p_ident[i] = 0;
      p_cap[i] = 0;
      p_used[i] = 0;
      p_load[i] = 0;
    end
    p_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_count(4'd8);
    for (int i = 0; i < 8; i++)
      queue_request(CMD_LOAD, i[2:0], 8'(i), (i == 7) ? MASK48 : 48'(i * 1000), '0, '0, 16'd1);
    queue_request(CMD_SETLOAD, 3'd1, '0, '0, 17'd65536, '0, 16'd1);
    queue_request(CMD_SETLOAD, 3'd2, '0, '0, 17'h1FFFF, '0, 16'd1);
    queue_request(CMD_ALLOC, '0, 8'd7, MASK48, '0, '0, 16'd1);
    queue_request(CMD_ALLOC, '0, 8'd7, 48'd5, '0, '0, 16'd1);
    queue_request(CMD_FREE, '0, 8'd3, MASK48, '0, '0, 16'd1);
    queue_request(CMD_ALLOC, '0, 8'd99, 48'd5, '0, '0, 16'd1);
    queue_request(CMD_BEST, '0, '0, '0, '0, '0, 16'd1);
    queue_request(CMD_BEST, '0, '0, MASK48, '0, '0, 16'd1);
    queue_request(CMD_SPLIT, '0, '0, '0, '0, 32'hFFFF_FFFF, 16'hFFFF);
    queue_request(CMD_SPLIT, '0, '0, '0, '0, 32'd1000, 16'd0);
    queue_request(CMD_SPLIT, '0, '0, '0, '0, 32'd0, 16'd1);
    queue_request(3'd6, '0, '0, '0, '0, '0, 16'd1);
    queue_request(3'd7, 3'd7, 8'hFF, MASK48, 17'h1FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      write_count(counts[ph]);
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 27 : 0;
      for (int k = 0; k < 62; k++) begin
        if ($urandom_range(3) == 0) queue_request(CMD_LOAD, 3'($urandom_range(7)),
            8'($urandom_range(10)), 48'({$urandom, $urandom}), '0, '0, 16'd1);
        pending.insert(pending.size(), random_request($urandom_range(9) != 0));
      end
      if (ph == 3) begin
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_drained();
    end
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
